/* src/ccsf_pkg.sv */
// ============================================================================
// Common-cover span finder: shared types and constants
// Item layouts for both channels, the sweep broadcast to the band cells and
// the running next-edge candidate handed along the cell row.
// ============================================================================
`default_nettype none

package ccsf_pkg;

    localparam int FREQ_BITS = 40;
    localparam int ANT_BITS  = 3;
    localparam int REQ_BITS  = 4;
    localparam int ACNT_BITS = 4;
    localparam int CCNT_BITS = 5;
    localparam int OP_BITS   = 2;

    localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_ANALYSE = 2'd2;

    typedef logic [FREQ_BITS-1:0] freq_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  operation;
        freq_t               band_low;
        freq_t               band_high;
        logic [ANT_BITS-1:0] antenna;
    } in_item_t;

    typedef struct packed {
        freq_t                span_low;
        freq_t                span_high;
        logic [ACNT_BITS-1:0] antenna_count;
        logic [CCNT_BITS-1:0] cover_count;
        logic                 adjoins_next;
        logic                 found;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        freq_t lo;
        freq_t hi;
        logic  first;
    } sweep_t;

    typedef struct packed {
        logic  valid;
        freq_t value;
    } cand_t;

endpackage : ccsf_pkg

`default_nettype wire

/* src/ccsf_cell.sv */
// ============================================================================
// Common-cover span finder: band cell
// Holds one stored band and adds its share to the token passing through:
// coverage of the swept interval, new antennas and the next edge candidate.
// ============================================================================
`default_nettype none

module ccsf_cell #(
    parameter int MAX_ANTENNAS = 8,
    parameter int CNTW         = 5
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire ccsf_pkg::freq_t         wr_low,
    input  wire ccsf_pkg::freq_t         wr_high,
    input  wire logic [MAX_ANTENNAS-1:0] wr_mask,
    input  wire logic                    active,
    input  wire ccsf_pkg::sweep_t        sweep,
    input  wire logic [MAX_ANTENNAS-1:0] seen_in,
    input  wire logic [ccsf_pkg::ACNT_BITS-1:0] ants_in,
    input  wire logic [CNTW-1:0]         bands_in,
    input  wire ccsf_pkg::cand_t         cand_in,
    output logic [MAX_ANTENNAS-1:0]      seen_out,
    output logic [ccsf_pkg::ACNT_BITS-1:0] ants_out,
    output logic [CNTW-1:0]              bands_out,
    output ccsf_pkg::cand_t              cand_out
);
    import ccsf_pkg::*;

    freq_t                   low_reg;
    freq_t                   high_reg;
    logic [MAX_ANTENNAS-1:0] mask_reg;

    logic [MAX_ANTENNAS-1:0] seen_next;
    logic [ACNT_BITS-1:0]    ants_next;
    logic [CNTW-1:0]         bands_next;
    cand_t                   cand_next;

    logic  covered;
    logic  new_ant;
    logic  cand_ok;
    freq_t cand_val;

    always_comb begin
        covered  = active && !sweep.first && (sweep.lo >= low_reg) && (sweep.hi <= high_reg);
        new_ant  = covered && ((seen_in & mask_reg) == '0);
        seen_next  = covered ? (seen_in | mask_reg) : seen_in;
        ants_next  = ants_in + ACNT_BITS'(new_ant);
        bands_next = bands_in + CNTW'(covered);

        if (sweep.first) begin
            cand_val = low_reg;
        end else if (low_reg > sweep.hi) begin
            cand_val = low_reg;
        end else begin
            cand_val = high_reg;
        end
        cand_ok = active && (sweep.first || (high_reg > sweep.hi));

        if (cand_ok && (!cand_in.valid || (cand_val < cand_in.value))) begin
            cand_next = '{valid: 1'b1, value: cand_val};
        end else begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            low_reg  <= wr_low;
            high_reg <= wr_high;
            mask_reg <= wr_mask;
        end
        seen_out  <= seen_next;
        ants_out  <= ants_next;
        bands_out <= bands_next;
        cand_out  <= cand_next;
    end

endmodule : ccsf_cell

`default_nettype wire

/* src/ccsf_chain.sv */
// ============================================================================
// Common-cover span finder: row of band cells
// One cell per stored band; the token moves one cell per cycle and the tail
// of the row gives the totals for the interval being swept.
// ============================================================================
`default_nettype none

module ccsf_chain #(
    parameter int MAX_BANDS    = 16,
    parameter int MAX_ANTENNAS = 8,
    parameter int CNTW         = 5
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire ccsf_pkg::freq_t         wr_low,
    input  wire ccsf_pkg::freq_t         wr_high,
    input  wire logic [MAX_ANTENNAS-1:0] wr_mask,
    input  wire logic [CNTW-1:0]         count,
    input  wire ccsf_pkg::sweep_t        sweep,
    output logic [MAX_ANTENNAS-1:0]      tail_seen,
    output logic [ccsf_pkg::ACNT_BITS-1:0] tail_ants,
    output logic [CNTW-1:0]              tail_bands,
    output ccsf_pkg::cand_t              tail_cand
);
    import ccsf_pkg::*;

    logic [MAX_ANTENNAS-1:0] seen_w  [MAX_BANDS+1];
    logic [ACNT_BITS-1:0]    ants_w  [MAX_BANDS+1];
    logic [CNTW-1:0]         bands_w [MAX_BANDS+1];
    cand_t                   cand_w  [MAX_BANDS+1];

    assign seen_w[0]  = '0;
    assign ants_w[0]  = '0;
    assign bands_w[0] = '0;
    assign cand_w[0]  = '0;

    for (genvar i = 0; i < MAX_BANDS; i++) begin : g_cell
        ccsf_cell #(
            .MAX_ANTENNAS(MAX_ANTENNAS),
            .CNTW        (CNTW)
        ) u_cell (
            .aclk     (aclk),
            .wr_en    (wr_en && (count == CNTW'(i))),
            .wr_low   (wr_low),
            .wr_high  (wr_high),
            .wr_mask  (wr_mask),
            .active   (count > CNTW'(i)),
            .sweep    (sweep),
            .seen_in  (seen_w[i]),
            .ants_in  (ants_w[i]),
            .bands_in (bands_w[i]),
            .cand_in  (cand_w[i]),
            .seen_out (seen_w[i+1]),
            .ants_out (ants_w[i+1]),
            .bands_out(bands_w[i+1]),
            .cand_out (cand_w[i+1])
        );
    end

    assign tail_seen  = seen_w[MAX_BANDS];
    assign tail_ants  = ants_w[MAX_BANDS];
    assign tail_bands = bands_w[MAX_BANDS];
    assign tail_cand  = cand_w[MAX_BANDS];

endmodule : ccsf_chain

`default_nettype wire

/* src/common_cover_span_finder_top.sv */
// ============================================================================
// Common-cover span finder: top level
// Stores up to MAX_BANDS bands in a row of cells and walks the distinct band
// edges in ascending order, emitting every interval covered by at least
// required_antennas distinct antennas and at least as many bands.
// ============================================================================
//
//  Channel  Ports               Direction  Item
//  s_       s_valid/s_ready     in         operation, band edges, antenna
//  m_       m_valid/m_ready     out        one kept interval or not-found
//  cfg_     cfg_valid/cfg_ready in         required_antennas (4 bit)
//
//  A clear, a load or an unused operation is taken while idle and s_ready
//  stays high. An analysis with D distinct edges runs D+1 sweeps of the
//  cell row, then emits the final item.
//  A sweep lasts as long as the token takes to pass the whole row of cells.
//  A full output register holds the walk until m_ready takes the item.
//  Reset empties the band store and sets required_antennas to 1.
//
`default_nettype none

module common_cover_span_finder_top #(
    parameter int MAX_BANDS    = 16,
    parameter int MAX_ANTENNAS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ccsf_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ccsf_pkg::out_item_t       m_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [ccsf_pkg::REQ_BITS-1:0] cfg_data
);
    import ccsf_pkg::*;

    localparam int CNTW  = $clog2(MAX_BANDS + 1);
    localparam int WAITW = $clog2(MAX_BANDS);
    localparam int CMPW  = (CNTW > REQ_BITS) ? CNTW : REQ_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t               state_reg,     state_next;
    logic [CNTW-1:0]      count_reg,     count_next;
    logic [REQ_BITS-1:0]  req_reg,       req_next;
    freq_t                lo_reg,        lo_next;
    freq_t                hi_reg,        hi_next;
    logic                 first_reg,     first_next;
    logic                 skip_reg,      skip_next;
    logic [WAITW-1:0]     wait_reg,      wait_next;
    logic                 pend_valid_reg, pend_valid_next;
    out_item_t            pend_reg,      pend_next;
    logic                 m_valid_reg,   m_valid_next;
    out_item_t            m_item_reg,    m_item_next;

    logic                    s_accept;
    logic                    wr_en;
    freq_t                   wr_low;
    freq_t                   wr_high;
    logic [MAX_ANTENNAS-1:0] wr_mask;
    logic [ANT_BITS-1:0]     ant_mod;
    sweep_t                  sweep;
    logic [MAX_ANTENNAS-1:0] tail_seen;
    logic [ACNT_BITS-1:0]    tail_ants;
    logic [CNTW-1:0]         tail_bands;
    cand_t                   tail_cand;
    logic                    out_free;
    logic                    kept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign sweep     = '{lo: lo_reg, hi: hi_reg, first: first_reg};

    always_comb begin
        ant_mod = s_item.antenna;
        for (int s = 0; s < 8; s++) begin
            if (32'(ant_mod) >= MAX_ANTENNAS) begin
                ant_mod = ant_mod - ANT_BITS'(MAX_ANTENNAS);
            end
        end
        for (int i = 0; i < MAX_ANTENNAS; i++) begin
            wr_mask[i] = (32'(ant_mod) == i);
        end
        if (s_item.band_low > s_item.band_high) begin
            wr_low  = s_item.band_high;
            wr_high = s_item.band_low;
        end else begin
            wr_low  = s_item.band_low;
            wr_high = s_item.band_high;
        end
        wr_en = s_accept && (s_item.operation == OP_LOAD) && (count_reg < CNTW'(MAX_BANDS));
    end

    ccsf_chain #(
        .MAX_BANDS   (MAX_BANDS),
        .MAX_ANTENNAS(MAX_ANTENNAS),
        .CNTW        (CNTW)
    ) u_chain (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_low    (wr_low),
        .wr_high   (wr_high),
        .wr_mask   (wr_mask),
        .count     (count_reg),
        .sweep     (sweep),
        .tail_seen (tail_seen),
        .tail_ants (tail_ants),
        .tail_bands(tail_bands),
        .tail_cand (tail_cand)
    );

    assign kept = !skip_reg
               && (CMPW'(tail_ants)  >= CMPW'(req_reg))
               && (CMPW'(tail_bands) >= CMPW'(req_reg));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        first_next      = first_reg;
        skip_next       = skip_reg;
        wait_next       = wait_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            req_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_item.operation)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_LOAD: begin
                            if (wr_en) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_ANALYSE: begin
                            first_next      = 1'b1;
                            skip_next       = 1'b1;
                            wait_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WAITW'(MAX_BANDS - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (first_reg) begin
                    if (!tail_cand.valid) begin
                        state_next = ST_FINISH;
                    end else begin
                        lo_next    = tail_cand.value;
                        hi_next    = tail_cand.value;
                        first_next = 1'b0;
                        skip_next  = 1'b1;
                        wait_next  = '0;
                        state_next = ST_SWEEP;
                    end
                end else if (!(kept && pend_valid_reg && !out_free)) begin
                    if (kept) begin
                        if (pend_valid_reg) begin
                            m_item_next              = pend_reg;
                            m_item_next.adjoins_next = (pend_reg.span_high == lo_reg);
                            m_valid_next             = 1'b1;
                        end
                        pend_next.span_low      = lo_reg;
                        pend_next.span_high     = hi_reg;
                        pend_next.antenna_count = tail_ants;
                        pend_next.cover_count   = CCNT_BITS'(tail_bands);
                        pend_next.adjoins_next  = 1'b0;
                        pend_next.found         = 1'b1;
                        pend_next.last          = 1'b0;
                        pend_valid_next         = 1'b1;
                    end
                    if (tail_cand.valid) begin
                        lo_next    = hi_reg;
                        hi_next    = tail_cand.value;
                        skip_next  = 1'b0;
                        wait_next  = '0;
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_item_next              = pend_reg;
                        m_item_next.adjoins_next = 1'b0;
                        m_item_next.last         = 1'b1;
                    end else begin
                        m_item_next      = '0;
                        m_item_next.last = 1'b1;
                    end
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            req_reg        <= REQ_BITS'(1);
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            req_reg        <= req_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        first_reg  <= first_next;
        skip_reg   <= skip_next;
        wait_reg   <= wait_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

    // The band store must not change while an analysis is under way.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("band count changed during analysis");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_BANDS))
        else $error("band count beyond capacity");

    // At the end of a sweep the antenna count agrees with the antenna mask.
    a_ants_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> ($countones(tail_seen) == 32'(tail_ants)))
        else $error("antenna count disagrees with antenna mask");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.found) |-> (m_item.last && (m_item.cover_count == '0)))
        else $error("malformed not-found item");

endmodule : common_cover_span_finder_top

`default_nettype wire
